// ===== hw/rtl/tae_pkg.sv =====
// Shared types, codes and helper functions for the Thumb ALU execute block.
// Depends on nothing; the core module imports it.
package tae_pkg;

   // Operation kinds carried on the request tuser field.
   typedef enum logic [4:0] {
      KIND_ADD  = 5'd0,
      KIND_ADC  = 5'd1,
      KIND_SUB  = 5'd2,
      KIND_CMP  = 5'd3,
      KIND_CMN  = 5'd4,
      KIND_AND  = 5'd5,
      KIND_ORR  = 5'd6,
      KIND_EOR  = 5'd7,
      KIND_BIC  = 5'd8,
      KIND_MVN  = 5'd9,
      KIND_MOV  = 5'd10,
      KIND_TST  = 5'd11,
      KIND_LSL  = 5'd12,
      KIND_ASR  = 5'd13,
      KIND_MUL  = 5'd14,
      KIND_CLZ  = 5'd15,
      KIND_BFC  = 5'd16,
      KIND_BFI  = 5'd17,
      KIND_UBFX = 5'd18,
      KIND_UXTB = 5'd19,
      KIND_CBZ  = 5'd20
   } kind_type;

   // Condition codes; any code not listed behaves as always.
   typedef enum logic [3:0] {
      COND_EQ = 4'd0,
      COND_NE = 4'd1,
      COND_HS = 4'd2,
      COND_LO = 4'd3,
      COND_MI = 4'd4,
      COND_PL = 4'd5,
      COND_VS = 4'd6,
      COND_VC = 4'd7,
      COND_HI = 4'd8,
      COND_LS = 4'd9,
      COND_GE = 4'd10,
      COND_LT = 4'd11,
      COND_GT = 4'd12,
      COND_LE = 4'd13,
      COND_AL = 4'd14
   } cond_type;

   // Operand shift types; unlisted codes mean no shift.
   typedef enum logic [2:0] {
      SHIFT_NONE = 3'd0,
      SHIFT_LSL  = 3'd1,
      SHIFT_LSR  = 3'd2,
      SHIFT_ASR  = 3'd3,
      SHIFT_ROR  = 3'd4
   } shift_kind_type;

   localparam int unsigned WORD_BITS = 32;
   localparam logic [7:0]  WORD_SHIFT_LIMIT = 8'd32;
   localparam logic [31:0] BYTE_MASK = 32'h0000_00FF;

   // NZCV flag bundle, N in the top bit.
   typedef struct packed {
      logic n;
      logic z;
      logic c;
      logic v;
   } nzcv_type;

   // Request payload as packed on req_tdata, last field in the lowest bits.
   typedef struct packed {
      logic [3:0]  pad;
      logic        branch_if_nonzero;
      logic [5:0]  field_width;
      logic [4:0]  field_lsb;
      logic        set_flags;
      logic [7:0]  shift_amount;
      logic [2:0]  shift_type;
      logic [31:0] operand_b;
      logic [31:0] operand_a;
      logic [3:0]  cond;
   } req_data_type;

   // Response payload as packed on rsp_tdata.
   typedef struct packed {
      logic        pad;
      nzcv_type    flags_out;
      logic        take_branch;
      logic        condition_passed;
      logic        write_result;
      logic [31:0] result;
   } rsp_data_type;

   // Barrel shift with carry-out; returns {carry, value}.
   function automatic logic [32:0] shift_carry(logic [31:0] value, logic [2:0] stype,
                                               logic [7:0] amount, logic carry_in);
      logic [63:0] wide;
      logic [5:0]  clamp;
      logic [32:0] outv;
      clamp = (amount > WORD_SHIFT_LIMIT) ? 6'd32 : amount[5:0];
      outv  = {carry_in, value};
      wide  = '0;
      if (amount != 8'd0) begin
         unique case (stype)
            SHIFT_LSL: begin
               wide = {32'd0, value} << clamp;
               outv = (amount > WORD_SHIFT_LIMIT) ? 33'd0 : {wide[32], wide[31:0]};
            end
            SHIFT_LSR: begin
               wide = {value, 32'd0} >> clamp;
               outv = (amount > WORD_SHIFT_LIMIT) ? 33'd0 : {wide[31], wide[63:32]};
            end
            SHIFT_ASR: begin
               wide = $signed({value, 32'd0}) >>> clamp;
               outv = {wide[31], wide[63:32]};
            end
            SHIFT_ROR: begin
               wide = {value, value} >> amount[4:0];
               outv = {wide[31], wide[31:0]};
            end
            default: begin
               outv = {carry_in, value};
            end
         endcase
      end
      return outv;
   endfunction

   // Mask of the k lowest bits, k from 0 to 32.
   function automatic logic [31:0] low_ones(logic [5:0] k);
      return ~(32'hFFFF_FFFF << k);
   endfunction

   // Count of leading zeros, 32 for a zero word.
   function automatic logic [5:0] count_leading_zeros(logic [31:0] x);
      logic [5:0] count;
      count = 6'd32;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (x[i]) begin
            count = 6'(WORD_BITS - 1 - i);
         end
      end
      return count;
   endfunction

   // Condition test against the stored flags.
   function automatic logic cond_holds(logic [3:0] cond, nzcv_type f);
      logic pass;
      unique case (cond)
         COND_EQ: pass = f.z;
         COND_NE: pass = !f.z;
         COND_HS: pass = f.c;
         COND_LO: pass = !f.c;
         COND_MI: pass = f.n;
         COND_PL: pass = !f.n;
         COND_VS: pass = f.v;
         COND_VC: pass = !f.v;
         COND_HI: pass = f.c && !f.z;
         COND_LS: pass = !f.c || f.z;
         COND_GE: pass = (f.n == f.v);
         COND_LT: pass = (f.n != f.v);
         COND_GT: pass = !f.z && (f.n == f.v);
         COND_LE: pass = f.z || (f.n != f.v);
         default: pass = 1'b1;
      endcase
      return pass;
   endfunction

endpackage

// ===== hw/rtl/thumb_alu_execute_with_flags_core.sv =====
// Thumb data-processing execute stage with stored NZCV flags.
// Depends on tae_pkg for operation codes, payload layouts and helper functions.

// The core takes one decoded Thumb data-processing operation per transaction and
// returns exactly one response transaction for it. A request is first captured in an
// input register; from there a single pass of logic tests the condition code against
// the stored NZCV flags, runs the operand shifter, the shared add-with-carry adder,
// the multiplier and the bit-field logic, and loads the response register and the
// flags register on the same clock edge. Because the flags are written as the
// operation leaves the input register, the next operation already sees them, so a
// new request can be accepted on every cycle while the response side does not stall,
// and each request passes the input register and then the response register. The two
// registers are separate stages, so one more request is still taken while a
// finished response waits for rsp_tready; after that req_tready stays low until the
// response leaves. An operation whose condition fails writes nothing and
// leaves the flags; cmp, cmn and tst always set the flags, while clz, the bit-field
// operations, uxtb and cbz/cbnz never do. flags_out reports the flags after the
// operation. Reset clears the flags to zero.
module thumb_alu_execute_with_flags_core
   import tae_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // req_tdata, lowest bit up: cond[3:0], operand_a[35:4], operand_b[67:36],
   // shift_type[70:68], shift_amount[78:71], set_flags[79], field_lsb[84:80],
   // field_width[90:85], branch_if_nonzero[91], zero fill[95:92].
   input  logic [95:0] req_tdata,
   // req_tuser: kind[4:0].
   input  logic [4:0]  req_tuser,
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // rsp_tdata, lowest bit up: result[31:0], write_result[32], condition_passed[33],
   // take_branch[34], flags_out[38:35] (N in bit 38 down to V in bit 35), zero fill[39].
   output logic [39:0] rsp_tdata
);

   // Input register stage.
   logic         s1_valid_ff, s1_valid_in;
   req_data_type s1_data_ff;
   logic [4:0]   s1_kind_ff;
   logic         s1_move;

   // Response register stage and architectural flags.
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;
   nzcv_type     flags_ff, flags_in;

   // Datapath signals.
   logic [32:0]  op_shift;
   logic [31:0]  bs;
   logic         sc;
   logic [32:0]  lr_shift;
   logic [31:0]  add_op2;
   logic         add_cin;
   logic [32:0]  add_sum;
   logic         add_v;
   logic [31:0]  mul_res;
   logic [6:0]   field_end_raw;
   logic [5:0]   field_end;
   logic [31:0]  fmask;
   logic         passed;
   logic [31:0]  res;
   logic         wr;
   logic         br;
   logic         setf;
   logic         upd;
   logic         new_c;
   logic         new_v;
   req_data_type d;

   // The input stage empties when its operation moves into the response register.
   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign d          = s1_data_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_tvalid && req_tready) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Operand shifter on operand_b, and the shifter used by the lsl and asr kinds.
   assign op_shift = shift_carry(d.operand_b, d.shift_type, d.shift_amount, flags_ff.c);
   assign bs       = op_shift[31:0];
   assign sc       = op_shift[32];
   assign lr_shift = shift_carry(d.operand_a,
                                 (s1_kind_ff == KIND_ASR) ? SHIFT_ASR : SHIFT_LSL,
                                 d.shift_amount, flags_ff.c);

   // One add-with-carry adder serves add, adc, sub, cmp and cmn.
   always_comb begin
      add_op2 = bs;
      add_cin = 1'b0;
      unique case (s1_kind_ff)
         KIND_ADC: add_cin = flags_ff.c;
         KIND_SUB, KIND_CMP: begin
            add_op2 = ~bs;
            add_cin = 1'b1;
         end
         default: add_cin = 1'b0;
      endcase
   end

   assign add_sum = {1'b0, d.operand_a} + {1'b0, add_op2} + {32'd0, add_cin};
   assign add_v   = ((d.operand_a ^ add_sum[31:0]) & (add_op2 ^ add_sum[31:0])) >> 31 != 32'd0;
   assign mul_res = d.operand_a * bs;

   // Bit-field mask, clipped at bit 31; an empty field gives an empty mask.
   assign field_end_raw = {2'b00, d.field_lsb} + {1'b0, d.field_width};
   assign field_end     = (field_end_raw > 7'd32) ? 6'd32 : field_end_raw[5:0];
   assign fmask         = (d.field_width == 6'd0) ? 32'd0
                        : (low_ones(field_end) & ~low_ones({1'b0, d.field_lsb}));

   assign passed = cond_holds(d.cond, flags_ff);

   // Result selection, destination write and flag update for the operation.
   always_comb begin
      res   = 32'd0;
      wr    = 1'b0;
      br    = 1'b0;
      upd   = 1'b0;
      setf  = d.set_flags;
      new_c = flags_ff.c;
      new_v = flags_ff.v;
      if (passed) begin
         wr = 1'b1;
         unique case (s1_kind_ff)
            KIND_ADD, KIND_ADC, KIND_SUB: begin
               res   = add_sum[31:0];
               new_c = add_sum[32];
               new_v = add_v;
               upd   = 1'b1;
            end
            KIND_CMP, KIND_CMN: begin
               res   = add_sum[31:0];
               new_c = add_sum[32];
               new_v = add_v;
               upd   = 1'b1;
               setf  = 1'b1;
               wr    = 1'b0;
            end
            KIND_AND: begin
               res = d.operand_a & bs; new_c = sc; upd = 1'b1;
            end
            KIND_ORR: begin
               res = d.operand_a | bs; new_c = sc; upd = 1'b1;
            end
            KIND_EOR: begin
               res = d.operand_a ^ bs; new_c = sc; upd = 1'b1;
            end
            KIND_BIC: begin
               res = d.operand_a & ~bs; new_c = sc; upd = 1'b1;
            end
            KIND_MVN: begin
               res = ~bs; new_c = sc; upd = 1'b1;
            end
            KIND_MOV: begin
               res = bs; new_c = sc; upd = 1'b1;
            end
            KIND_TST: begin
               res   = d.operand_a & bs;
               new_c = sc;
               upd   = 1'b1;
               setf  = 1'b1;
               wr    = 1'b0;
            end
            KIND_LSL, KIND_ASR: begin
               res = lr_shift[31:0]; new_c = lr_shift[32]; upd = 1'b1;
            end
            KIND_MUL: begin
               // Multiply sets only N and Z.
               res = mul_res; upd = 1'b1;
            end
            KIND_CLZ:  res = {26'd0, count_leading_zeros(bs)};
            KIND_BFC:  res = d.operand_a & ~fmask;
            KIND_BFI:  res = (d.operand_a & ~fmask) | ((bs << d.field_lsb) & fmask);
            KIND_UBFX: res = (d.operand_a & fmask) >> d.field_lsb;
            KIND_UXTB: res = bs & BYTE_MASK;
            KIND_CBZ: begin
               wr = 1'b0;
               br = (d.operand_a == 32'd0) ^ d.branch_if_nonzero;
            end
            default: begin
               // Undefined kinds do nothing but still report the condition.
               wr = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      flags_in = flags_ff;
      if (s1_move && upd && setf) begin
         flags_in.n = res[31];
         flags_in.z = (res == 32'd0);
         flags_in.c = new_c;
         flags_in.v = new_v;
      end
   end

   always_comb begin
      rsp_data_in                  = rsp_data_ff;
      if (s1_move) begin
         rsp_data_in.pad              = 1'b0;
         rsp_data_in.result           = res;
         rsp_data_in.write_result     = wr;
         rsp_data_in.condition_passed = passed;
         rsp_data_in.take_branch      = br;
         rsp_data_in.flags_out        = flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         flags_ff     <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_data_ff <= req_data_type'(req_tdata);
         s1_kind_ff <= req_tuser;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A failed condition neither writes a destination nor takes a branch.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.condition_passed |->
         !rsp_data_ff.write_result && !rsp_data_ff.take_branch)
      else $error("failed condition produced a write or a branch");

   // A branch decision never comes with a destination write.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.write_result && rsp_data_ff.take_branch))
      else $error("branch and write reported together");

   // The flags only change when an operation leaves the input stage.
   assert property (@(posedge clock) disable iff (reset)
      !s1_move |=> $stable(flags_ff))
      else $error("flags changed without an operation");

   // A pending response always reports the current flags.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.flags_out == flags_ff))
      else $error("response flags differ from stored flags");

endmodule

// ===== tb/thumb_alu_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the Thumb ALU execute core: predicts every response from the
// accepted requests and compares it field by field. Depends on tae_pkg for payload layouts.
module thumb_alu_result_checker
   import tae_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [95:0] req_tdata,
   input  logic [4:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   output int          mismatches,
   output int          outstanding
);

   typedef enum logic [1:0] {
      UPD_NONE,
      UPD_NZCV,
      UPD_NZC,
      UPD_NZ
   } flag_update_type;

   nzcv_type     predicted_flags;
   rsp_data_type expected_results[$];
   int           mismatch_total;
   int           response_index;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_total++;
      $display("MISMATCH response %0d %s: got %h, expected %h (t=%0t)",
               response_index, what, got, want, $realtime);
   endtask

   // Operand shifter: returns {carry, value}.
   function automatic logic [32:0] operand_shift(logic [31:0] v, logic [2:0] st,
                                                 logic [7:0] n, logic cin);
      int          k;
      logic [31:0] rot;
      logic [4:0]  m;
      k = n;
      m = n[4:0];
      if (k == 0) return {cin, v};
      case (st)
         SHIFT_LSL: begin
            if (k < 32) return {v[32 - k], v << k};
            return {(k == 32) ? v[0] : 1'b0, 32'd0};
         end
         SHIFT_LSR: begin
            if (k < 32) return {v[k - 1], v >> k};
            return {(k == 32) ? v[31] : 1'b0, 32'd0};
         end
         SHIFT_ASR: begin
            if (k < 32) return {v[k - 1], $signed(v) >>> k};
            return {v[31], {32{v[31]}}};
         end
         SHIFT_ROR: begin
            rot = (m == 5'd0) ? v : ((v >> m) | (v << (32 - m)));
            return {rot[31], rot};
         end
         default: return {cin, v};
      endcase
   endfunction

   // Returns {carry, overflow, sum}.
   function automatic logic [33:0] add_with_flags(logic [31:0] a, logic [31:0] b, logic cin);
      logic [32:0] s;
      logic        ov;
      s  = {1'b0, a} + {1'b0, b} + {32'd0, cin};
      ov = (a[31] ^ s[31]) & (b[31] ^ s[31]);
      return {s[32], ov, s[31:0]};
   endfunction

   function automatic logic [31:0] low_mask(int k);
      return (k >= 32) ? 32'hFFFF_FFFF : ((32'd1 << k) - 32'd1);
   endfunction

   function automatic logic [31:0] leading_zeros(logic [31:0] v);
      logic [31:0] count;
      logic        found;
      count = '0;
      found = 1'b0;
      for (int i = 31; i >= 0; i--) begin
         if (v[i]) found = 1'b1;
         else if (!found) count++;
      end
      return count;
   endfunction

   function automatic logic condition_met(logic [3:0] cond, nzcv_type f);
      case (cond)
         COND_EQ: return f.z;
         COND_NE: return !f.z;
         COND_HS: return f.c;
         COND_LO: return !f.c;
         COND_MI: return f.n;
         COND_PL: return !f.n;
         COND_VS: return f.v;
         COND_VC: return !f.v;
         COND_HI: return f.c && !f.z;
         COND_LS: return !f.c || f.z;
         COND_GE: return f.n == f.v;
         COND_LT: return f.n != f.v;
         COND_GT: return !f.z && (f.n == f.v);
         COND_LE: return f.z || (f.n != f.v);
         default: return 1'b1;
      endcase
   endfunction

   // Executes one operation against the predicted flags and returns its response.
   function automatic rsp_data_type execute_op(logic [4:0] kind, req_data_type op);
      rsp_data_type    r;
      nzcv_type        f;
      flag_update_type upd;
      logic [32:0]     sh;
      logic [33:0]     sum;
      logic [31:0]     a, bs, res, fmask;
      logic            pass, sf, c, v, wr, br;
      int              fend;
      f     = predicted_flags;
      a     = op.operand_a;
      pass  = condition_met(op.cond, f);
      sh    = operand_shift(op.operand_b, op.shift_type, op.shift_amount, f.c);
      bs    = sh[31:0];
      fend  = int'(op.field_lsb) + int'(op.field_width);
      if (fend > 32) fend = 32;
      fmask = (op.field_width == 6'd0) ? 32'd0 : (low_mask(fend) & ~low_mask(op.field_lsb));
      res   = '0;
      wr    = 1'b0;
      br    = 1'b0;
      upd   = UPD_NONE;
      sf    = op.set_flags;
      c     = f.c;
      v     = f.v;
      sum   = '0;
      if (pass && kind <= KIND_CBZ) begin
         wr = 1'b1;
         case (kind)
            KIND_ADD: sum = add_with_flags(a, bs, 1'b0);
            KIND_ADC: sum = add_with_flags(a, bs, f.c);
            KIND_SUB: sum = add_with_flags(a, ~bs, 1'b1);
            KIND_CMP: sum = add_with_flags(a, ~bs, 1'b1);
            KIND_CMN: sum = add_with_flags(a, bs, 1'b0);
            default: ;
         endcase
         case (kind)
            KIND_ADD, KIND_ADC, KIND_SUB, KIND_CMP, KIND_CMN: begin
               {c, v, res} = sum;
               upd = UPD_NZCV;
            end
            KIND_AND, KIND_TST: begin res = a & bs; c = sh[32]; upd = UPD_NZC; end
            KIND_ORR: begin res = a | bs;  c = sh[32]; upd = UPD_NZC; end
            KIND_EOR: begin res = a ^ bs;  c = sh[32]; upd = UPD_NZC; end
            KIND_BIC: begin res = a & ~bs; c = sh[32]; upd = UPD_NZC; end
            KIND_MVN: begin res = ~bs;     c = sh[32]; upd = UPD_NZC; end
            KIND_MOV: begin res = bs;      c = sh[32]; upd = UPD_NZC; end
            KIND_LSL: begin
               {c, res} = operand_shift(a, SHIFT_LSL, op.shift_amount, f.c);
               upd = UPD_NZC;
            end
            KIND_ASR: begin
               {c, res} = operand_shift(a, SHIFT_ASR, op.shift_amount, f.c);
               upd = UPD_NZC;
            end
            KIND_MUL:  begin res = a * bs; upd = UPD_NZ; end
            KIND_CLZ:  res = leading_zeros(bs);
            KIND_BFC:  res = a & ~fmask;
            KIND_BFI:  res = (a & ~fmask) | ((bs << op.field_lsb) & fmask);
            KIND_UBFX: res = (op.field_width == 6'd0) ? 32'd0 :
                             ((a >> op.field_lsb) & low_mask(fend - int'(op.field_lsb)));
            KIND_UXTB: res = bs & BYTE_MASK;
            default: begin
               wr = 1'b0;
               br = (a == 32'd0) != op.branch_if_nonzero;
            end
         endcase
         // Compares always write the flags but never a register.
         if (kind == KIND_CMP || kind == KIND_CMN || kind == KIND_TST) begin
            sf = 1'b1;
            wr = 1'b0;
         end
         if (upd != UPD_NONE && sf) begin
            if (upd == UPD_NZ) c = f.c;
            if (upd != UPD_NZCV) v = f.v;
            predicted_flags = '{n: res[31], z: (res == 32'd0), c: c, v: v};
         end
      end
      r                  = '0;
      r.result           = res;
      r.write_result     = wr;
      r.condition_passed = pass;
      r.take_branch      = br;
      r.flags_out        = predicted_flags;
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      rsp_data_type got, want;
      if (reset) begin
         expected_results.delete();
         predicted_flags = '0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(execute_op(req_tuser, req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_results.size() == 0) begin
               report_mismatch("arrived with nothing expected", got.result, 32'd0);
            end else begin
               want = expected_results.pop_front();
               if (got.result !== want.result)
                  report_mismatch("result", got.result, want.result);
               if (got.write_result !== want.write_result)
                  report_mismatch("write_result", 32'(got.write_result),
                                  32'(want.write_result));
               if (got.condition_passed !== want.condition_passed)
                  report_mismatch("condition_passed", 32'(got.condition_passed),
                                  32'(want.condition_passed));
               if (got.take_branch !== want.take_branch)
                  report_mismatch("take_branch", 32'(got.take_branch),
                                  32'(want.take_branch));
               if (got.flags_out !== want.flags_out)
                  report_mismatch("flags_out", 32'(got.flags_out), 32'(want.flags_out));
            end
            response_index++;
         end
      end
      outstanding <= expected_results.size();
      mismatches  <= mismatch_total;
   end

endmodule

// ===== tb/tb_thumb_alu_execute_with_flags_core.sv =====
`timescale 1ns / 100ps
// Top of the testbench for the Thumb ALU execute core: clock, reset, request and
// response stimulus, and the verdict. Depends on tae_pkg, the core and the result checker.
module tb_thumb_alu_execute_with_flags_core
   import tae_pkg::*;
();

   // Codes that the package leaves unnamed but the block must still tolerate.
   localparam logic [3:0] COND_ALWAYS_ALT  = 4'd15;
   localparam logic [4:0] KIND_NONE_FIRST  = 5'd21;
   localparam logic [4:0] KIND_NONE_LAST   = 5'd31;
   localparam logic [2:0] SHIFT_RESERVED   = 3'd5;
   localparam logic [2:0] SHIFT_RESERVED_7 = 3'd7;

   localparam int CYCLE_LIMIT       = 400000;
   localparam int LONG_STALL_CYCLES = 200;
   localparam int DRAIN_CYCLES      = 20;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;
   logic [4:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;

   int          mismatches;
   int          outstanding;
   int          cycle_count;

   // Handshake between the stimulus and the receiver process. Both are written with
   // nonblocking assignments so the receiver sees them without ever racing.
   logic        rx_idle_on;
   logic        long_stall_req;
   // Sender gaps are local to the stimulus process, so a plain variable does.
   logic        sender_gaps;

   thumb_alu_execute_with_flags_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   thumb_alu_result_checker result_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Watchdog: a hung handshake anywhere ends the run here.
   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   // Packs one request payload; the zero fill above branch_if_nonzero stays clear.
   function automatic req_data_type make_op(logic [3:0] cond, logic [31:0] a, logic [31:0] b,
                                            logic [2:0] st, logic [7:0] amt, logic sf,
                                            logic [4:0] lsb, logic [5:0] width, logic nz);
      req_data_type op;
      op                   = '0;
      op.cond              = cond;
      op.operand_a         = a;
      op.operand_b         = b;
      op.shift_type        = st;
      op.shift_amount      = amt;
      op.set_flags         = sf;
      op.field_lsb         = lsb;
      op.field_width       = width;
      op.branch_if_nonzero = nz;
      return op;
   endfunction

   // Operand values lean on the corners where carry, overflow and zero flip.
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return $urandom_range(0, 255);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [7:0] pick_amount();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd32;
         2: return 8'd33;
         3: return 8'd255;
         4, 5: return 8'($urandom_range(1, 31));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Mostly unconditional operations so that flags build up, but every condition code
   // and every unused shift and kind code still shows up regularly.
   function automatic req_data_type random_op();
      logic [3:0] cond;
      logic [2:0] st;
      logic [5:0] width;
      cond  = ($urandom_range(0, 9) < 6) ? COND_AL : 4'($urandom_range(0, 15));
      st    = ($urandom_range(0, 9) < 4) ? SHIFT_NONE : 3'($urandom_range(0, 7));
      width = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(1, 32)) :
                                           6'($urandom_range(0, 63));
      return make_op(cond, pick_word(), pick_word(), st, pick_amount(),
                     1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)), width,
                     1'($urandom_range(0, 1)));
   endfunction

   function automatic logic [4:0] random_kind();
      if ($urandom_range(0, 9) == 0) return 5'($urandom_range(KIND_NONE_FIRST, KIND_NONE_LAST));
      return 5'($urandom_range(KIND_ADD, KIND_CBZ));
   endfunction

   // Offers one transaction and holds it until the core takes it; then maybe idles.
   task automatic send_op(input logic [4:0] kind, input req_data_type op);
      req_tvalid <= 1'b1;
      req_tdata  <= op;
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   // Stops offering and waits for every expected response. The first edge lets the
   // checker's count catch up with the last accepted request.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) send_op(random_kind(), random_op());
   endtask

   // Receiver: ready most of the time, with random stall bursts while idling is on, and
   // one long hold-off that backs the core up into its request side.
   initial begin : receiver
      logic long_stall_served;
      long_stall_served = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_stall_req && !long_stall_served) begin
            long_stall_served = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_STALL_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      reset          <= 1'b1;
      req_tvalid     <= 1'b0;
      req_tdata      <= '0;
      req_tuser      <= '0;
      rx_idle_on     <= 1'b0;
      long_stall_req <= 1'b0;
      sender_gaps    = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part: every operation at least once, the shifter corners, the compare kinds with
      // set_flags clear, the flagless kinds, the unused codes and clipped or empty fields.
      // Conditional items follow items whose flags are known.
      send_op(KIND_MOV, make_op(COND_AL, 32'd0, 32'h8000_0000, SHIFT_NONE, 8'd0, 1'b1,
                                5'd0, 6'd1, 1'b0));
      send_op(KIND_ADD, make_op(COND_MI, 32'hFFFF_FFFF, 32'd1, SHIFT_NONE, 8'd0, 1'b1,
                                5'd0, 6'd1, 1'b0));
      send_op(KIND_ADC, make_op(COND_EQ, 32'h7FFF_FFFF, 32'd0, SHIFT_NONE, 8'd0, 1'b1,
                                5'd0, 6'd1, 1'b0));
      send_op(KIND_SUB, make_op(COND_VS, 32'd0, 32'd1, SHIFT_NONE, 8'd0, 1'b1,
                                5'd0, 6'd1, 1'b0));
      send_op(KIND_CMP, make_op(COND_LT, 32'd5, 32'd5, SHIFT_NONE, 8'd0, 1'b0,
                                5'd0, 6'd1, 1'b0));
      send_op(KIND_CMN, make_op(COND_HI, 32'h8000_0000, 32'h8000_0000, SHIFT_NONE, 8'd0,
                                1'b0, 5'd0, 6'd1, 1'b0));
      send_op(KIND_AND, make_op(COND_GE, 32'hFFFF_FFFF, 32'd1, SHIFT_LSL, 8'd32, 1'b1,
                                5'd0, 6'd1, 1'b0));
      send_op(KIND_ORR, make_op(COND_LS, 32'd0, 32'h8000_0000, SHIFT_LSR, 8'd32, 1'b1,
                                5'd0, 6'd1, 1'b0));
      send_op(KIND_EOR, make_op(COND_GT, 32'h1234_5678, 32'h8000_0000, SHIFT_ASR, 8'd40,
                                1'b1, 5'd0, 6'd1, 1'b0));
      send_op(KIND_BIC, make_op(COND_LE, 32'hFFFF_FFFF, 32'h8000_0001, SHIFT_ROR, 8'd64,
                                1'b1, 5'd0, 6'd1, 1'b0));
      send_op(KIND_MVN, make_op(COND_PL, 32'd0, 32'hFFFF_FFFF, SHIFT_LSL, 8'd33, 1'b1,
                                5'd0, 6'd1, 1'b0));
      send_op(KIND_TST, make_op(COND_NE, 32'hFFFF_FFFF, 32'h8000_0000, SHIFT_RESERVED,
                                8'd4, 1'b0, 5'd0, 6'd1, 1'b0));
      send_op(KIND_LSL, make_op(COND_HS, 32'd1, 32'd0, SHIFT_NONE, 8'd32, 1'b1,
                                5'd0, 6'd1, 1'b0));
      send_op(KIND_ASR, make_op(COND_AL, 32'h8000_0000, 32'd0, SHIFT_NONE, 8'd255, 1'b1,
                                5'd0, 6'd1, 1'b0));
      send_op(KIND_MUL, make_op(COND_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SHIFT_NONE, 8'd0,
                                1'b1, 5'd0, 6'd1, 1'b0));
      send_op(KIND_CLZ, make_op(COND_VC, 32'd0, 32'd0, SHIFT_RESERVED_7, 8'd9, 1'b1,
                                5'd0, 6'd1, 1'b0));
      send_op(KIND_BFC, make_op(COND_AL, 32'hFFFF_FFFF, 32'd0, SHIFT_NONE, 8'd0, 1'b1,
                                5'd28, 6'd10, 1'b0));
      send_op(KIND_BFI, make_op(COND_AL, 32'h0F0F_0F0F, 32'hFFFF_FFFF, SHIFT_NONE, 8'd0,
                                1'b1, 5'd4, 6'd0, 1'b0));
      send_op(KIND_BFI, make_op(COND_AL, 32'd0, 32'hFFFF_FFFF, SHIFT_LSR, 8'd1, 1'b1,
                                5'd31, 6'd32, 1'b0));
      send_op(KIND_UBFX, make_op(COND_AL, 32'hFFFF_FFFF, 32'd0, SHIFT_NONE, 8'd0, 1'b1,
                                 5'd31, 6'd63, 1'b0));
      send_op(KIND_UXTB, make_op(COND_AL, 32'd0, 32'hABCD_EF12, SHIFT_ROR, 8'd8, 1'b1,
                                 5'd0, 6'd1, 1'b0));
      send_op(KIND_CBZ, make_op(COND_ALWAYS_ALT, 32'd0, 32'd0, SHIFT_NONE, 8'd0, 1'b1,
                                5'd0, 6'd1, 1'b0));
      send_op(KIND_CBZ, make_op(COND_AL, 32'd0, 32'd0, SHIFT_NONE, 8'd0, 1'b1,
                                5'd0, 6'd1, 1'b1));
      send_op(KIND_NONE_LAST, make_op(COND_AL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SHIFT_NONE,
                                      8'd0, 1'b1, 5'd0, 6'd1, 1'b0));
      send_op(KIND_NONE_FIRST, make_op(COND_EQ, 32'd1, 32'd1, SHIFT_NONE, 8'd0, 1'b1,
                                       5'd0, 6'd1, 1'b0));

      // Random traffic with idle bursts on both sides.
      sender_gaps = 1'b1;
      rx_idle_on <= 1'b1;
      send_random(500);

      // The receiver holds off for a long stretch while requests keep coming back to
      // back, so the core fills up and drops req_tready. Then the sender waits until
      // every response is back before going on.
      sender_gaps = 1'b0;
      long_stall_req <= 1'b1;
      send_random(60);
      wait_drained();

      sender_gaps = 1'b1;
      send_random(440);

      // Last stretch runs at full rate with no idling on either side.
      sender_gaps = 1'b0;
      rx_idle_on <= 1'b0;
      send_random(200);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
